/* rtl/trigs_pkg.sv */
// trigs_pkg: shared widths, codes, item and config types for the grid sampler
// no dependencies; used by every module under rtl except trigs_ram
`timescale 1ns / 1ps
package trigs_pkg;

  localparam int unsigned WORLD_W    = 32;
  localparam int unsigned OFF_W      = WORLD_W + 1;
  localparam int unsigned IDX_W      = 13;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  // grid coordinates and weights cover chunk sizes up to 64
  localparam int unsigned COORD_W    = 7;
  localparam int unsigned WGT_W      = 7;
  localparam int unsigned CNT_SQ_W   = 13;
  localparam int unsigned FLAT_W     = 19;
  localparam int unsigned WPAIR_W    = 2 * WGT_W;
  localparam int unsigned WPROD_W    = 3 * WGT_W;
  localparam int unsigned PROD_W     = VAL_W + WPROD_W + 1;
  localparam int unsigned SUM_W      = PROD_W + 3;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned NCORNER    = 8;
  localparam int unsigned NAXIS      = 3;

  localparam logic [STEP_W-1:0] FALLBACK_STEP_LOG2 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LOG2_RESET    = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 2'd0,
    CFG_ORIGIN_Y  = 2'd1,
    CFG_ORIGIN_Z  = 2'd2,
    CFG_STEP_LOG2 = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // values derived from the step register, held steady between config writes
  typedef struct packed {
    logic [STEP_W-1:0]   eff_s;
    logic [WGT_W-1:0]    step;
    logic [COORD_W-1:0]  count;
    logic [COORD_W-1:0]  cell_max;
    logic [CNT_SQ_W-1:0] count_sq;
    logic [SHIFT_W-1:0]  shift;
    logic [SUM_W-1:0]    bias;
  } grid_cfg_t;

  // classified beat handed from the front to the back
  typedef struct packed {
    op_e                           op;
    logic                          last;
    logic [IDX_W-1:0]              index;
    logic [VAL_W-1:0]              value;
    logic [NAXIS-1:0][COORD_W-1:0] grid_pos;
    logic [NAXIS-1:0][WGT_W-1:0]   wgt;
  } item_t;

  function automatic logic [VAL_W-1:0] sat_value(input logic [SUM_W-1:0] v);
    logic [VAL_W-1:0] res;
    res = v[VAL_W-1:0];
    if (!v[SUM_W-1] && (|v[SUM_W-2:VAL_W-1])) begin
      res = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (v[SUM_W-1] && !(&v[SUM_W-2:VAL_W-1])) begin
      res = {1'b1, {(VAL_W-1){1'b0}}};
    end
    return res;
  endfunction

endpackage

/* rtl/trigs_ram.sv */
// trigs_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
module trigs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4913
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/trigs_front.sv */
// trigs_front: input register, origin subtract and cell / weight split per axis
// depends on trigs_pkg
`timescale 1ns / 1ps
module trigs_front (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_ready_o,
  input  logic                                             op_i,
  input  logic [trigs_pkg::IDX_W-1:0]                      entry_index_i,
  input  logic [trigs_pkg::VAL_W-1:0]                      entry_value_i,
  input  logic                                             last_entry_i,
  input  logic [trigs_pkg::NAXIS-1:0][trigs_pkg::WORLD_W-1:0] world_i,
  input  logic [trigs_pkg::NAXIS-1:0][trigs_pkg::WORLD_W-1:0] origin_i,
  input  trigs_pkg::grid_cfg_t                             cfg_i,
  output logic                                             item_valid_o,
  input  logic                                             item_ready_i,
  output trigs_pkg::item_t                                 item_o
);

  logic                                  fv_q;
  logic                                  op_q;
  logic                                  last_q;
  logic [trigs_pkg::IDX_W-1:0]           index_q;
  logic [trigs_pkg::VAL_W-1:0]           value_q;
  logic [trigs_pkg::NAXIS-1:0][trigs_pkg::WORLD_W-1:0] world_q;
  logic                                  accept;
  logic [trigs_pkg::OFF_W-1:0]           off      [trigs_pkg::NAXIS];
  logic [trigs_pkg::OFF_W-1:0]           cell_raw [trigs_pkg::NAXIS];
  logic [trigs_pkg::OFF_W-1:0]           cell_lim;

  assign in_ready_o = ~fv_q | item_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (accept) begin
      fv_q <= 1'b1;
    end else if (item_ready_i) begin
      fv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      last_q  <= last_entry_i;
      index_q <= entry_index_i;
      value_q <= entry_value_i;
      world_q <= world_i;
    end
  end

  assign cell_lim = {{(trigs_pkg::OFF_W-trigs_pkg::COORD_W){1'b0}}, cfg_i.cell_max};

  always_comb begin
    item_o.op    = trigs_pkg::op_e'(op_q);
    item_o.last  = last_q;
    item_o.index = index_q;
    item_o.value = value_q;
    for (int a = 0; a < trigs_pkg::NAXIS; a++) begin
      off[a] = {world_q[a][trigs_pkg::WORLD_W-1], world_q[a]}
             - {origin_i[a][trigs_pkg::WORLD_W-1], origin_i[a]};
      cell_raw[a] = off[a] >> cfg_i.eff_s;
      if (off[a][trigs_pkg::OFF_W-1] || (off[a] == '0)) begin
        // at or below the grid origin
        item_o.grid_pos[a] = '0;
        item_o.wgt[a]      = '0;
      end else if (cell_raw[a] > cell_lim) begin
        // past the last cell: pin to the far corner
        item_o.grid_pos[a] = cfg_i.cell_max;
        item_o.wgt[a]      = cfg_i.step;
      end else begin
        item_o.grid_pos[a] = cell_raw[a][trigs_pkg::COORD_W-1:0];
        item_o.wgt[a]      = off[a][trigs_pkg::WGT_W-1:0]
                           & (cfg_i.step - trigs_pkg::WGT_W'(1));
      end
    end
  end

  assign item_valid_o = fv_q;

  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fv_q && !item_ready_i) |=> (fv_q && $stable(world_q) && $stable(index_q)))
    else $error("front register changed while the queue was full");

endmodule

/* rtl/trigs_fifo.sv */
// trigs_fifo: short queue of classified beats between front and back
// depends on trigs_pkg
`timescale 1ns / 1ps
module trigs_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  trigs_pkg::item_t push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output trigs_pkg::item_t pop_item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  trigs_pkg::item_t   mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               push;
  logic               pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_fifo_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("queue fill count lost a pushed beat");

endmodule

/* rtl/trigs_back.sv */
// trigs_back: grid store (eight read copies), weight products, blend and output register
// depends on trigs_pkg and trigs_ram
`timescale 1ns / 1ps
module trigs_back #(
  parameter int unsigned GRID_DEPTH = 4913
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  trigs_pkg::item_t            item_i,
  input  trigs_pkg::grid_cfg_t        cfg_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [trigs_pkg::VAL_W-1:0] sample_value_o,
  output logic                        grid_was_ready_o
);

  localparam int unsigned ADDR_W  = $clog2(GRID_DEPTH);
  localparam int unsigned FLAT_W  = trigs_pkg::FLAT_W;
  localparam int unsigned WGT_W   = trigs_pkg::WGT_W;
  localparam int unsigned WPAIR_W = trigs_pkg::WPAIR_W;
  localparam int unsigned WPROD_W = trigs_pkg::WPROD_W;
  localparam int unsigned PROD_W  = trigs_pkg::PROD_W;
  localparam int unsigned SUM_W   = trigs_pkg::SUM_W;
  localparam int unsigned VAL_W   = trigs_pkg::VAL_W;
  localparam int unsigned NC      = trigs_pkg::NCORNER;

  logic adv;

  // stage 1: flat base index and xy weight pairs
  logic                             s1_valid_q;
  trigs_pkg::op_e                   s1_op_q;
  logic                             s1_last_q;
  logic [trigs_pkg::IDX_W-1:0]      s1_index_q;
  logic [VAL_W-1:0]                 s1_value_q;
  logic [FLAT_W-1:0]                s1_base_q, s1_base_d;
  logic [3:0][WPAIR_W-1:0]          s1_wxy_q, s1_wxy_d;
  logic [1:0][WGT_W-1:0]            s1_wz_q, s1_wz_d;
  logic [1:0][WGT_W-1:0]            wx, wy;

  // stage 2: corner data out of the rams, full weights
  logic                             s2_valid_q;
  logic                             s2_ready_q;
  logic [NC-1:0][WPROD_W-1:0]       s2_w_q, s2_w_d;
  logic [NC-1:0][VAL_W-1:0]         ram_rdata;
  logic [NC-1:0][ADDR_W-1:0]        ram_raddr;
  logic [NC-1:0][FLAT_W-1:0]        corner_off;
  logic                             ram_we;
  logic [ADDR_W-1:0]                ram_waddr;
  logic                             grid_ready_q;

  // stages 3 to 5: products and adder tree
  logic                             s3_valid_q, s3_ready_q;
  logic [NC-1:0][PROD_W-1:0]        s3_prod_q, s3_prod_d;
  logic                             s4_valid_q, s4_ready_q;
  logic [3:0][SUM_W-1:0]            s4_sum_q, s4_sum_d;
  logic                             s5_valid_q, s5_ready_q;
  logic [1:0][SUM_W-1:0]            s5_sum_q, s5_sum_d;

  // output register
  logic                             out_valid_q;
  logic                             out_ready_q;
  logic [VAL_W-1:0]                 out_value_q, out_value_d;
  logic [SUM_W-1:0]                 total;
  logic [SUM_W-1:0]                 rounded;

  // the whole back pipeline moves together, frozen only by the output beat
  assign adv          = ~out_valid_q | out_ready_i;
  assign item_ready_o = adv;

  always_comb begin
    wx[0] = cfg_i.step - item_i.wgt[0];
    wx[1] = item_i.wgt[0];
    wy[0] = cfg_i.step - item_i.wgt[1];
    wy[1] = item_i.wgt[1];
    s1_wz_d[0] = cfg_i.step - item_i.wgt[2];
    s1_wz_d[1] = item_i.wgt[2];
    for (int j = 0; j < 4; j++) begin
      s1_wxy_d[j] = {{WGT_W{1'b0}}, wx[j%2]} * {{WGT_W{1'b0}}, wy[j/2]};
    end
    s1_base_d = {{(FLAT_W-trigs_pkg::COORD_W){1'b0}}, item_i.grid_pos[0]}
              + {{(FLAT_W-trigs_pkg::COORD_W){1'b0}}, item_i.grid_pos[1]}
              * {{(FLAT_W-trigs_pkg::COORD_W){1'b0}}, cfg_i.count}
              + {{(FLAT_W-trigs_pkg::COORD_W){1'b0}}, item_i.grid_pos[2]}
              * {{(FLAT_W-trigs_pkg::CNT_SQ_W){1'b0}}, cfg_i.count_sq};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q    <= item_i.op;
      s1_last_q  <= item_i.last;
      s1_index_q <= item_i.index;
      s1_value_q <= item_i.value;
      s1_base_q  <= s1_base_d;
      s1_wxy_q   <= s1_wxy_d;
      s1_wz_q    <= s1_wz_d;
    end
  end

  // corner i sits at dx = i[0], dy = i[1], dz = i[2]
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      corner_off[i] = FLAT_W'(i % 2)
                    + (((i / 2) % 2 == 1) ?
                       {{(FLAT_W-trigs_pkg::COORD_W){1'b0}}, cfg_i.count} : '0)
                    + ((i / 4 == 1) ?
                       {{(FLAT_W-trigs_pkg::CNT_SQ_W){1'b0}}, cfg_i.count_sq} : '0);
      ram_raddr[i] = ADDR_W'(s1_base_q + corner_off[i]);
      s2_w_d[i]    = {{WGT_W{1'b0}}, s1_wxy_q[i%4]}
                   * {{WPAIR_W{1'b0}}, s1_wz_q[i/4]};
    end
  end

  assign ram_we    = adv & s1_valid_q & (s1_op_q == trigs_pkg::OP_LOAD)
                   & (32'(s1_index_q) < 32'(GRID_DEPTH));
  assign ram_waddr = ADDR_W'(s1_index_q);

  // every copy takes every write so each corner has a read port of its own
  for (genvar g = 0; g < NC; g++) begin : g_copy
    trigs_ram #(
      .WIDTH (VAL_W),
      .DEPTH (GRID_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (ram_waddr),
      .wdata_i (s1_value_q),
      .re_i    (adv),
      .raddr_i (ram_raddr[g]),
      .rdata_o (ram_rdata[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_w_q     <= s2_w_d;
      s2_ready_q <= grid_ready_q;
      s3_prod_q  <= s3_prod_d;
      s3_ready_q <= s2_ready_q;
      s4_sum_q   <= s4_sum_d;
      s4_ready_q <= s3_ready_q;
      s5_sum_q   <= s5_sum_d;
      s5_ready_q <= s4_ready_q;
      out_value_q <= out_value_d;
      out_ready_q <= s5_ready_q;
    end
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      s3_prod_d[i] = {{(PROD_W-VAL_W){ram_rdata[i][VAL_W-1]}}, ram_rdata[i]}
                   * {{(PROD_W-WPROD_W){1'b0}}, s2_w_q[i]};
    end
    for (int j = 0; j < 4; j++) begin
      s4_sum_d[j] = {{(SUM_W-PROD_W){s3_prod_q[2*j][PROD_W-1]}}, s3_prod_q[2*j]}
                  + {{(SUM_W-PROD_W){s3_prod_q[2*j+1][PROD_W-1]}}, s3_prod_q[2*j+1]};
    end
    for (int j = 0; j < 2; j++) begin
      s5_sum_d[j] = s4_sum_q[2*j] + s4_sum_q[2*j+1];
    end
    // round half up, then floor by the cube of the step
    total       = s5_sum_q[0] + s5_sum_q[1] + cfg_i.bias;
    rounded     = $signed(total) >>> cfg_i.shift;
    out_value_d = s5_ready_q ? trigs_pkg::sat_value(rounded) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      s4_valid_q   <= 1'b0;
      s5_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      grid_ready_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= item_valid_i;
      s2_valid_q  <= s1_valid_q & (s1_op_q == trigs_pkg::OP_SAMPLE);
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
      if (s1_valid_q && (s1_op_q == trigs_pkg::OP_LOAD) && s1_last_q) begin
        grid_ready_q <= 1'b1;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sample_value_o   = out_value_q;
  assign grid_was_ready_o = out_ready_q;

  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grid_ready_q |=> grid_ready_q)
    else $error("grid ready flag dropped without reset");

  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !grid_was_ready_o) |-> (sample_value_o == '0))
    else $error("sample before grid load returned a nonzero value");

endmodule

/* rtl/trilinear_grid_sampler_core.sv */
// trilinear_grid_sampler_core: top level, config registers and front / queue / back
// depends on trigs_pkg, trigs_front, trigs_fifo, trigs_back, trigs_ram
`timescale 1ns / 1ps
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------------
//  in      | in_valid_i/in_ready_o | op, entry_index, entry_value, last_entry, world_*
//  out     | out_valid_o/out_ready_i | sample_value, grid_was_ready (one per sample)
//  cfg     | cfg_we_i              | cfg_index_i, cfg_data_i (no wait, no read-back)
//
// one beat per cycle in and out while the output is not stalled; a sample result
// passes the front register, the queue, stages 1 to 5 and the output register.
// the rate is set by eight copies of the grid store, one read port per corner.
// reset clears control and config only; grid contents are undefined until loaded,
// with no clearing pass. an output stall freezes the back pipeline; a four-deep
// queue and the front register keep taking input beats until they fill.
module trilinear_grid_sampler_core #(
  parameter int unsigned CHUNK_SIZE = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [trigs_pkg::IDX_W-1:0]      entry_index_i,
  input  logic [trigs_pkg::VAL_W-1:0]      entry_value_i,
  input  logic                             last_entry_i,
  input  logic [trigs_pkg::WORLD_W-1:0]    world_x_i,
  input  logic [trigs_pkg::WORLD_W-1:0]    world_y_i,
  input  logic [trigs_pkg::WORLD_W-1:0]    world_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [trigs_pkg::VAL_W-1:0]      sample_value_o,
  output logic                             grid_was_ready_o,
  input  logic                             cfg_we_i,
  input  logic [trigs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [trigs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned GRID_DEPTH = (CHUNK_SIZE + 1) * (CHUNK_SIZE + 1) * (CHUNK_SIZE + 1);
  localparam logic [7:0]  CHUNK_V    = 8'(CHUNK_SIZE);

  logic [trigs_pkg::NAXIS-1:0][trigs_pkg::WORLD_W-1:0] origin_q;
  logic [trigs_pkg::NAXIS-1:0][trigs_pkg::WORLD_W-1:0] world;
  logic [trigs_pkg::STEP_W-1:0]  step_q;
  trigs_pkg::grid_cfg_t          cfg_q, cfg_d;
  logic [7:0]                    step_mask;
  logic [7:0]                    count_w;
  logic [2*trigs_pkg::COORD_W-1:0] count_sq;

  trigs_pkg::item_t q_in_item, q_out_item;
  logic             q_in_valid, q_in_ready;
  logic             q_out_valid, q_out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      step_q   <= trigs_pkg::STEP_LOG2_RESET;
    end else if (cfg_we_i) begin
      case (trigs_pkg::cfg_reg_e'(cfg_index_i))
        trigs_pkg::CFG_ORIGIN_X:  origin_q[0] <= cfg_data_i;
        trigs_pkg::CFG_ORIGIN_Y:  origin_q[1] <= cfg_data_i;
        trigs_pkg::CFG_ORIGIN_Z:  origin_q[2] <= cfg_data_i;
        trigs_pkg::CFG_STEP_LOG2: step_q      <= cfg_data_i[trigs_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // a step that does not divide the chunk falls back to spacing 4
  always_comb begin
    step_mask      = (8'd1 << step_q) - 8'd1;
    cfg_d.eff_s    = ((CHUNK_V & step_mask) == 8'd0) ? step_q
                                                     : trigs_pkg::FALLBACK_STEP_LOG2;
    cfg_d.step     = trigs_pkg::WGT_W'(8'd1 << cfg_d.eff_s);
    count_w        = (CHUNK_V >> cfg_d.eff_s) + 8'd1;
    cfg_d.count    = trigs_pkg::COORD_W'(count_w);
    cfg_d.cell_max = (count_w >= 8'd2) ? trigs_pkg::COORD_W'(count_w - 8'd2) : '0;
    count_sq       = {{trigs_pkg::COORD_W{1'b0}}, cfg_d.count}
                   * {{trigs_pkg::COORD_W{1'b0}}, cfg_d.count};
    cfg_d.count_sq = trigs_pkg::CNT_SQ_W'(count_sq);
    cfg_d.shift    = ({2'b00, cfg_d.eff_s} << 1) + {2'b00, cfg_d.eff_s};
    cfg_d.bias     = (cfg_d.shift == '0) ? '0
                   : (trigs_pkg::SUM_W'(1) << (cfg_d.shift - trigs_pkg::SHIFT_W'(1)));
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  assign world[0] = world_x_i;
  assign world[1] = world_y_i;
  assign world[2] = world_z_i;

  trigs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .last_entry_i  (last_entry_i),
    .world_i       (world),
    .origin_i      (origin_q),
    .cfg_i         (cfg_q),
    .item_valid_o  (q_in_valid),
    .item_ready_i  (q_in_ready),
    .item_o        (q_in_item)
  );

  trigs_fifo #(
    .DEPTH (4)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_in_valid),
    .push_ready_o (q_in_ready),
    .push_item_i  (q_in_item),
    .pop_valid_o  (q_out_valid),
    .pop_ready_i  (q_out_ready),
    .pop_item_o   (q_out_item)
  );

  trigs_back #(
    .GRID_DEPTH (GRID_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (q_out_valid),
    .item_ready_o     (q_out_ready),
    .item_i           (q_out_item),
    .cfg_i            (cfg_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_value_o   (sample_value_o),
    .grid_was_ready_o (grid_was_ready_o)
  );

endmodule
